@@ src/text_console_cursor_scroll_top_macros.svh @@
// Assertion macros shared by the console engine modules.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define CTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CTS_ASSERT(lbl, clk, rst, prop, msg)
`define CTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define CTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ src/cts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cts_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int MODE_W = 1;
  localparam int CHAR_W = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 7;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam logic [MODE_W-1:0] MODE_PUT  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;
  localparam int                TAB_STEP   = 8;
  localparam logic [ATTR_W-1:0] RESET_COLOR = 8'h07;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FILL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic exec;
    logic copy_rd;
    logic copy_wr;
    logic fill_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic need_scroll;
    logic at_last;
    logic copy_last;
    logic out_free;
  } sts_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [ATTR_W-1:0] attr);
    return {attr, ch};
  endfunction

endpackage

`default_nettype wire

@@ src/cts_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cts_req_if;
  logic                        valid;
  logic                        ready;
  logic [cts_pkg::MODE_W-1:0]  mode;
  logic [cts_pkg::CHAR_W-1:0]  char_code;
  logic [cts_pkg::RROW_W-1:0]  read_row;
  logic [cts_pkg::RCOL_W-1:0]  read_column;
  modport source (output valid, mode, char_code, read_row, read_column, input ready);
  modport sink   (input valid, mode, char_code, read_row, read_column, output ready);
endinterface

interface cts_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [cts_pkg::CELL_W-1:0]  cell_data;
  logic [cts_pkg::RROW_W-1:0]  cursor_row;
  logic [cts_pkg::RCOL_W-1:0]  cursor_column;
  logic                        scrolled;
  modport source (output valid, cell_data, cursor_row, cursor_column, scrolled, input ready);
  modport sink   (input valid, cell_data, cursor_row, cursor_column, scrolled, output ready);
endinterface

interface cts_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cts_pkg::ATTR_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/cts_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/cts_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_cursor_scroll_top_macros.svh"

module cts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cts_pkg::sts_t sts,
  output cts_pkg::cmd_t cmd
);

  cts_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cts_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cts_pkg::ST_CLEAR: begin
        if (sts.at_last) state_next = cts_pkg::ST_IDLE;
      end
      cts_pkg::ST_IDLE: begin
        if (in_valid) state_next = cts_pkg::ST_EXEC;
      end
      cts_pkg::ST_EXEC: begin
        if (!sts.is_read && sts.need_scroll) state_next = cts_pkg::ST_COPY_RD;
        else state_next = cts_pkg::ST_FINISH;
      end
      cts_pkg::ST_COPY_RD: begin
        state_next = cts_pkg::ST_COPY_WR;
      end
      cts_pkg::ST_COPY_WR: begin
        if (sts.copy_last) state_next = cts_pkg::ST_FILL;
        else state_next = cts_pkg::ST_COPY_RD;
      end
      cts_pkg::ST_FILL: begin
        if (sts.at_last) state_next = cts_pkg::ST_FINISH;
      end
      cts_pkg::ST_FINISH: begin
        if (sts.out_free) state_next = cts_pkg::ST_IDLE;
      end
      default: state_next = cts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      cts_pkg::ST_CLEAR:   cmd.clear_wr = 1'b1;
      cts_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      cts_pkg::ST_EXEC:    cmd.exec     = 1'b1;
      cts_pkg::ST_COPY_RD: cmd.copy_rd  = 1'b1;
      cts_pkg::ST_COPY_WR: cmd.copy_wr  = 1'b1;
      cts_pkg::ST_FILL:    cmd.fill_wr  = 1'b1;
      cts_pkg::ST_FINISH:  cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

  `CTS_ASSERT_IMPL(a_clear_after_reset, clk, rst, $past(rst), state == cts_pkg::ST_CLEAR, "no clearing pass after reset")
  `CTS_ASSERT_NEXT(a_scroll_entry, clk, rst, state == cts_pkg::ST_EXEC && !sts.is_read && sts.need_scroll, state == cts_pkg::ST_COPY_RD, "scroll not started")
  `CTS_ASSERT_NEXT(a_finish_exit, clk, rst, state == cts_pkg::ST_FINISH && sts.out_free, state == cts_pkg::ST_IDLE, "result loaded but not idle")

endmodule

`default_nettype wire

@@ src/cts_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_cursor_scroll_top_macros.svh"

module cts_datapath #(
  parameter int COLUMNS = cts_pkg::COLUMNS_DEF,
  parameter int ROWS    = cts_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cts_pkg::cmd_t               cmd,
  output cts_pkg::sts_t               sts,
  input  logic [cts_pkg::MODE_W-1:0]  mode,
  input  logic [cts_pkg::CHAR_W-1:0]  char_code,
  input  logic [cts_pkg::RROW_W-1:0]  read_row,
  input  logic [cts_pkg::RCOL_W-1:0]  read_column,
  input  logic                        cfg_valid,
  input  logic [cts_pkg::ATTR_W-1:0]  cfg_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [cts_pkg::CELL_W-1:0]  cell_data,
  output logic [cts_pkg::RROW_W-1:0]  cursor_row,
  output logic [cts_pkg::RCOL_W-1:0]  cursor_column,
  output logic                        scrolled
);

  localparam int NCELLS    = ROWS * COLUMNS;
  localparam int AW        = $clog2(NCELLS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int SW        = $clog2(COLUMNS + cts_pkg::TAB_STEP);
  localparam int NW        = $clog2(ROWS + 1);
  localparam int LAST      = NCELLS - 1;
  localparam int COPY_LAST = (ROWS - 1) * COLUMNS - 1;

  logic [cts_pkg::MODE_W-1:0] item_mode;
  logic [cts_pkg::CHAR_W-1:0] item_char;
  logic [cts_pkg::RROW_W-1:0] item_row;
  logic [cts_pkg::RCOL_W-1:0] item_col;
  logic [RW-1:0]              cur_row;
  logic [CW-1:0]              cur_col;
  logic [cts_pkg::ATTR_W-1:0] text_color;
  logic                       scroll_flag;
  logic [AW-1:0]              cnt;

  logic                       is_read;
  logic                       rd_ok;
  logic [SW-1:0]              col_ext;
  logic [SW-1:0]              col_sum;
  logic                       row_inc;
  logic                       put_wr;
  logic                       wrap;
  logic [NW-1:0]              row_sum;
  logic                       need_scroll;
  logic [RW-1:0]              row_new;
  logic [CW-1:0]              col_new;
  logic [AW-1:0]              cursor_addr;
  logic [AW-1:0]              read_addr;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [cts_pkg::CELL_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [cts_pkg::CELL_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode <= mode;
      item_char <= char_code;
      item_row  <= read_row;
      item_col  <= read_column;
    end
  end

  assign is_read     = (item_mode == cts_pkg::MODE_READ);
  assign rd_ok       = (int'(item_row) < ROWS) && (int'(item_col) < COLUMNS);
  assign cursor_addr = AW'(int'(cur_row) * COLUMNS + int'(cur_col));
  assign read_addr   = AW'(int'(item_row) * COLUMNS + int'(item_col));
  assign col_ext     = SW'(cur_col);

  always_comb begin
    col_sum = col_ext;
    row_inc = 1'b0;
    put_wr  = 1'b0;
    unique case (item_char)
      cts_pkg::CH_NEWLINE: begin
        col_sum = '0;
        row_inc = 1'b1;
      end
      cts_pkg::CH_RETURN: col_sum = '0;
      cts_pkg::CH_TAB: begin
        col_sum = (col_ext + SW'(cts_pkg::TAB_STEP)) & ~SW'(cts_pkg::TAB_STEP - 1);
      end
      default: begin
        col_sum = col_ext + SW'(1);
        put_wr  = 1'b1;
      end
    endcase
  end

  // Only one of a newline and a column wrap can happen for one character.
  assign wrap        = (col_sum >= SW'(COLUMNS));
  assign row_sum     = NW'(cur_row) + NW'(row_inc || wrap);
  assign need_scroll = (row_sum >= NW'(ROWS));
  assign row_new     = need_scroll ? RW'(ROWS - 1) : RW'(row_sum);
  assign col_new     = wrap ? '0 : CW'(col_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row     <= '0;
      cur_col     <= '0;
      text_color  <= cts_pkg::RESET_COLOR;
      scroll_flag <= 1'b0;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        text_color <= cfg_data;
      end
      if (cmd.exec) begin
        scroll_flag <= !is_read && need_scroll;
        if (!is_read) begin
          cur_row <= row_new;
          cur_col <= col_new;
        end
      end
      if (cmd.exec) begin
        cnt <= '0;
      end else if (cmd.clear_wr || cmd.copy_wr || cmd.fill_wr) begin
        cnt <= cnt + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cell_data     <= (is_read && rd_ok) ? ram_rdata : '0;
      cursor_row    <= cts_pkg::RROW_W'(cur_row);
      cursor_column <= cts_pkg::RCOL_W'(cur_col);
      scrolled      <= scroll_flag;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = ram_rdata;
    if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_wdata = cts_pkg::make_cell(cts_pkg::CH_BLANK, cts_pkg::RESET_COLOR);
    end else if (cmd.exec) begin
      ram_we    = !is_read && put_wr;
      ram_waddr = cursor_addr;
      ram_wdata = cts_pkg::make_cell(item_char, text_color);
    end else if (cmd.copy_wr) begin
      ram_we    = 1'b1;
    end else if (cmd.fill_wr) begin
      ram_we    = 1'b1;
      ram_wdata = cts_pkg::make_cell(cts_pkg::CH_BLANK, text_color);
    end
  end

  assign ram_re    = (cmd.exec && is_read) || cmd.copy_rd;
  assign ram_raddr = cmd.copy_rd ? (cnt + AW'(COLUMNS)) : read_addr;

  cts_ram #(
    .WIDTH (cts_pkg::CELL_W),
    .DEPTH (NCELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.is_read     = is_read;
    sts.need_scroll = need_scroll;
    sts.at_last     = (cnt == AW'(LAST));
    sts.copy_last   = (cnt == AW'(COPY_LAST));
    sts.out_free    = !out_valid || out_ready;
  end

  `CTS_ASSERT(a_cursor_bounds, clk, rst, (int'(cur_row) < ROWS) && (int'(cur_col) < COLUMNS), "cursor outside the screen")
  `CTS_ASSERT_IMPL(a_out_load, clk, rst, $rose(out_valid), $past(cmd.load_out), "result appeared without a load")
  `CTS_ASSERT_IMPL(a_copy_range, clk, rst, cmd.copy_wr, int'(cnt) <= COPY_LAST, "row copy beyond the upper rows")

endmodule

`default_nettype wire

@@ src/text_console_cursor_scroll_top.sv @@
// A request word taken in ST_IDLE goes through ST_EXEC and ST_FINISH, where its result word
// is loaded into the output register; a put that scrolls also alternates ST_COPY_RD and
// ST_COPY_WR over the upper rows and then runs ST_FILL over the bottom row, and a result still
// waiting in the output register holds the next one in ST_FINISH; no new request word is
// taken before the last has loaded its result. Reset (synchronous, active high) starts a
// clearing pass over all ROWS*COLUMNS cells, taking no request word but still colour writes.
`timescale 1ns / 1ps
`default_nettype none

// Text-mode console engine.
//
// The screen is held in a single RAM of ROWS*COLUMNS cells, each cell a
// character byte with its attribute byte above it. A small controller steps
// through the work for each request word, and the datapath holds the cursor,
// the colour register, the address counter and the result register.
//
// A put word runs the character rules in the EXEC state: newline, carriage return
// and tab move the cursor only, while any other byte is written at the cursor
// in the current colour before the cursor advances. When the cursor runs off
// the bottom row, the controller walks the store once, reading each cell one
// row further down and writing it back one row up, and then fills the bottom
// row with blanks in the current colour.
//
// A read word fetches one cell; coordinates outside the screen return zero.
//
// The result register sits between the engine and the response channel, so
// the next request word is taken while the previous result still waits.

module text_console_cursor_scroll_top #(
  parameter int COLUMNS = cts_pkg::COLUMNS_DEF,
  parameter int ROWS    = cts_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cts_req_if.sink    req,
  cts_rsp_if.source  rsp,
  cts_cfg_if.sink    cfg
);

  cts_pkg::cmd_t cmd;
  cts_pkg::sts_t sts;

  // The colour register can be written in any cycle outside reset.
  assign cfg.ready = 1'b1;

  cts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cts_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (req.mode),
    .char_code     (req.char_code),
    .read_row      (req.read_row),
    .read_column   (req.read_column),
    .cfg_valid     (cfg.valid),
    .cfg_data      (cfg.data),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .cell_data     (rsp.cell_data),
    .cursor_row    (rsp.cursor_row),
    .cursor_column (rsp.cursor_column),
    .scrolled      (rsp.scrolled)
  );

endmodule

`default_nettype wire
